FILE: hw/rtl/fss_pkg.sv
// Shared types, constants and bonus tables for the fuzzy subsequence scorer.
`default_nettype none
package fss_pkg;

  localparam int CHAR_W    = 8;
  localparam int SCORE_W   = 14;
  localparam int RUN_W     = 7;
  localparam int ADD_W     = 10;
  localparam int OP_W      = 2;

  localparam logic [SCORE_W-1:0] SCORE_MAX = 14'd16383;
  localparam logic [RUN_W-1:0]   RUN_MAX   = 7'd127;

  localparam int QUERY_DEPTH_DEF  = 64;
  localparam int HAYSTACK_MAX_DEF = 255;

  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
  localparam logic [OP_W-1:0] OP_HAY    = 2'd2;
  localparam logic [OP_W-1:0] OP_END    = 2'd3;

  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2f;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2e;
  localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5a;
  localparam logic [CHAR_W-1:0] CASE_OFS = 8'd32;

  localparam logic [ADD_W-1:0] HIT_BASE  = 10'd10;
  localparam logic [ADD_W-1:0] HIT_START = 10'd15;
  localparam logic [ADD_W-1:0] HIT_SEP   = 10'd10;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [CHAR_W-1:0] ch;
  } cmd_t;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic               matched;
  } res_t;

  function automatic logic [CHAR_W-1:0] fold(input logic [CHAR_W-1:0] c);
    return (c >= CH_UA && c <= CH_UZ) ? c + CASE_OFS : c;
  endfunction

  // 50/(n+1) for n below 64
  function automatic logic [5:0] len_bonus(input logic [5:0] n);
    logic [5:0] b;
    case (n) inside
      6'd0:      b = 6'd50;
      6'd1:      b = 6'd25;
      6'd2:      b = 6'd16;
      6'd3:      b = 6'd12;
      6'd4:      b = 6'd10;
      6'd5:      b = 6'd8;
      6'd6:      b = 6'd7;
      6'd7:      b = 6'd6;
      [6'd8:6'd9]:   b = 6'd5;
      [6'd10:6'd11]: b = 6'd4;
      [6'd12:6'd15]: b = 6'd3;
      [6'd16:6'd24]: b = 6'd2;
      [6'd25:6'd49]: b = 6'd1;
      default:   b = 6'd0;
    endcase
    return b;
  endfunction

  // 10/(p+1) for p below 16
  function automatic logic [3:0] first_bonus(input logic [3:0] p);
    logic [3:0] b;
    case (p) inside
      4'd0:        b = 4'd10;
      4'd1:        b = 4'd5;
      4'd2:        b = 4'd3;
      [4'd3:4'd4]: b = 4'd2;
      [4'd5:4'd9]: b = 4'd1;
      default:     b = 4'd0;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/fss_stream_if.sv
// Valid/ready stream interface carrying one item of payload type T.
`default_nettype none
interface fss_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/fss_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module fss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: hw/rtl/fss_alu.sv
// Shared saturating score adder.
`default_nettype none
module fss_alu (
  input  wire logic [fss_pkg::SCORE_W-1:0] a,
  input  wire logic [fss_pkg::ADD_W-1:0]   b,
  output logic      [fss_pkg::SCORE_W-1:0] y
);
  logic [fss_pkg::SCORE_W:0] sum;

  assign sum = {1'b0, a} + {{(fss_pkg::SCORE_W + 1 - fss_pkg::ADD_W){1'b0}}, b};
  assign y   = sum[fss_pkg::SCORE_W] ? fss_pkg::SCORE_MAX : sum[fss_pkg::SCORE_W-1:0];
endmodule
`default_nettype wire

FILE: hw/rtl/fuzzy_subsequence_scorer.sv
// Top level: fuzzy subsequence scorer sequencer with query RAM and shared adder.
//
//  channel  dir  payload               accepted when
//  cmd      in   op[1:0], ch[7:0]      cmd.valid & cmd.ready
//  result   out  score[13:0], matched  result.valid & result.ready
//
// Clear and append items are done on acceptance; haystack items go through a query RAM
// read, then compare and add through the shared adder; end items go through two bonus adds.
// An end item waits in its last step while the result register is still full.
// Reset (rst, synchronous) empties the query and the scan; the query RAM is
// not cleared. cmd.ready is low while an item is in work.
`default_nettype none
module fuzzy_subsequence_scorer #(
  parameter int QUERY_DEPTH  = fss_pkg::QUERY_DEPTH_DEF,
  parameter int HAYSTACK_MAX = fss_pkg::HAYSTACK_MAX_DEF
) (
  input wire logic      clk,
  input wire logic      rst,
  fss_stream_if.sink    cmd,
  fss_stream_if.source  result
);
  localparam int AW  = $clog2(QUERY_DEPTH);
  localparam int QLW = $clog2(QUERY_DEPTH + 1);
  localparam int HLW = $clog2(HAYSTACK_MAX + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_END1 = 2'd2;
  localparam logic [1:0] S_END2 = 2'd3;

  logic [1:0]                    state;
  logic [QLW-1:0]                query_length;
  logic [QLW-1:0]                match_index;
  logic [fss_pkg::SCORE_W-1:0]   running_score;
  logic [fss_pkg::RUN_W-1:0]     run_length;
  logic                          first_hit_valid;
  logic [HLW-1:0]                first_hit_position;
  logic [HLW-1:0]                haystack_length;
  logic [fss_pkg::CHAR_W-1:0]    previous_char;
  logic [fss_pkg::CHAR_W-1:0]    cur_char;
  logic [fss_pkg::SCORE_W-1:0]   acc;
  logic                          res_valid;
  logic [fss_pkg::SCORE_W-1:0]   res_score;
  logic                          res_matched;

  logic                          accept;
  logic [fss_pkg::OP_W-1:0]      op;
  logic [fss_pkg::CHAR_W-1:0]    ch;
  logic                          ram_we;
  logic [fss_pkg::CHAR_W-1:0]    ram_rdata;
  logic                          can_hit;
  logic                          hit;
  logic                          sep;
  logic [fss_pkg::ADD_W-1:0]     run_x5;
  logic [fss_pkg::ADD_W-1:0]     hit_add;
  logic [fss_pkg::ADD_W-1:0]     len_add;
  logic [fss_pkg::ADD_W-1:0]     first_add;
  logic [fss_pkg::SCORE_W-1:0]   alu_a;
  logic [fss_pkg::ADD_W-1:0]     alu_b;
  logic [fss_pkg::SCORE_W-1:0]   alu_y;
  logic                          ok;
  logic                          end_fire;
  logic                          restart;

  assign op        = cmd.data.op;
  assign ch        = cmd.data.ch;
  assign cmd.ready = (state == S_IDLE);
  assign accept    = cmd.valid && cmd.ready;
  assign ram_we    = accept && (op == fss_pkg::OP_APPEND) &&
                     (query_length < QLW'(QUERY_DEPTH));

  fss_ram #(
    .WIDTH (fss_pkg::CHAR_W),
    .DEPTH (QUERY_DEPTH)
  ) u_query (
    .clk   (clk),
    .we    (ram_we),
    .waddr (query_length[AW-1:0]),
    .wdata (ch),
    .raddr (match_index[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign can_hit = match_index < query_length;
  assign hit     = can_hit && (fss_pkg::fold(ram_rdata) == fss_pkg::fold(cur_char));
  assign sep     = (previous_char == fss_pkg::CH_SPACE) ||
                   (previous_char == fss_pkg::CH_SLASH) ||
                   (previous_char == fss_pkg::CH_DOT);
  assign run_x5  = ({3'b000, run_length} << 2) + {3'b000, run_length};

  always_comb begin
    hit_add = fss_pkg::HIT_BASE + run_x5;
    if (haystack_length == '0) begin
      hit_add = hit_add + fss_pkg::HIT_START;
    end else if (sep) begin
      hit_add = hit_add + fss_pkg::HIT_SEP;
    end
  end

  assign len_add   = (haystack_length < HLW'(50)) ?
                     {4'b0000, fss_pkg::len_bonus(haystack_length[5:0])} : '0;
  assign first_add = (first_hit_valid && first_hit_position < HLW'(10)) ?
                     {6'b000000, fss_pkg::first_bonus(first_hit_position[3:0])} : '0;

  always_comb begin
    alu_a = running_score;
    alu_b = hit_add;
    unique case (state)
      S_IDLE: alu_b = hit_add;
      S_CMP:  alu_b = hit_add;
      S_END1: alu_b = len_add;
      S_END2: begin
        alu_a = acc;
        alu_b = first_add;
      end
      default: alu_b = hit_add;
    endcase
  end

  fss_alu u_alu (
    .a (alu_a),
    .b (alu_b),
    .y (alu_y)
  );

  assign ok       = (query_length != '0) && (match_index >= query_length);
  assign end_fire = (state == S_END2) && (!res_valid || result.ready);
  assign restart  = (accept && (op == fss_pkg::OP_CLEAR || op == fss_pkg::OP_APPEND)) ||
                    end_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      query_length       <= '0;
      match_index        <= '0;
      running_score      <= '0;
      run_length         <= '0;
      first_hit_valid    <= 1'b0;
      first_hit_position <= '0;
      haystack_length    <= '0;
      previous_char      <= '0;
      res_valid          <= 1'b0;
    end else begin
      if (end_fire) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (op)
              fss_pkg::OP_CLEAR:  query_length <= '0;
              fss_pkg::OP_APPEND: begin
                if (ram_we) begin
                  query_length <= query_length + 1'b1;
                end
              end
              fss_pkg::OP_HAY: begin
                cur_char <= ch;
                state    <= S_CMP;
              end
              fss_pkg::OP_END: state <= S_END1;
              default: state <= S_IDLE;
            endcase
          end
        end
        S_CMP: begin
          if (hit) begin
            running_score <= alu_y;
            match_index   <= match_index + 1'b1;
            if (run_length < fss_pkg::RUN_MAX) begin
              run_length <= run_length + 1'b1;
            end
            if (!first_hit_valid) begin
              first_hit_valid    <= 1'b1;
              first_hit_position <= haystack_length;
            end
          end else if (can_hit) begin
            run_length <= '0;
          end
          if (haystack_length < HLW'(HAYSTACK_MAX)) begin
            haystack_length <= haystack_length + 1'b1;
          end
          previous_char <= cur_char;
          state         <= S_IDLE;
        end
        S_END1: begin
          acc   <= alu_y;
          state <= S_END2;
        end
        S_END2: begin
          if (end_fire) begin
            res_score   <= ok ? alu_y : '0;
            res_matched <= ok;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (restart) begin
        match_index        <= '0;
        running_score      <= '0;
        run_length         <= '0;
        first_hit_valid    <= 1'b0;
        first_hit_position <= '0;
        haystack_length    <= '0;
        previous_char      <= '0;
      end
    end
  end

  assign result.valid        = res_valid;
  assign result.data.score   = res_score;
  assign result.data.matched = res_matched;
endmodule
`default_nettype wire

FILE: hw/rtl/fss_checker.sv
// Port-level checker for the fuzzy subsequence scorer, bound to the top level.
`default_nettype none
module fss_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         cmd_valid,
  input wire logic                         cmd_ready,
  input wire logic [fss_pkg::OP_W-1:0]     cmd_op,
  input wire logic                         res_valid,
  input wire logic                         res_ready,
  input wire logic [fss_pkg::SCORE_W-1:0]  res_score,
  input wire logic                         res_matched
);
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_score) && $stable(res_matched))
    else $error("result item changed while stalled");

  a_nomatch_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_matched |-> res_score == '0)
    else $error("unmatched result with nonzero score");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result item present after reset");

  a_hay_busy: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready && cmd_op == fss_pkg::OP_HAY |=> !cmd_ready)
    else $error("ready during haystack compare");

  a_clear_fast: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready && cmd_op == fss_pkg::OP_CLEAR |=> cmd_ready)
    else $error("not ready after clear item");
endmodule

bind fuzzy_subsequence_scorer fss_checker u_fss_checker (
  .clk         (clk),
  .rst         (rst),
  .cmd_valid   (cmd.valid),
  .cmd_ready   (cmd.ready),
  .cmd_op      (cmd.data.op),
  .res_valid   (result.valid),
  .res_ready   (result.ready),
  .res_score   (result.data.score),
  .res_matched (result.data.matched)
);
`default_nettype wire

FILE: dv/testbench.sv
// Self-checking testbench for the fuzzy subsequence scorer: directed table, then random scans.
module testbench;

  localparam int QDEPTH    = fss_pkg::QUERY_DEPTH_DEF;
  localparam int QAW       = $clog2(QDEPTH);
  localparam int HAY_MAX   = fss_pkg::HAYSTACK_MAX_DEF;
  localparam int CW        = fss_pkg::CHAR_W;
  localparam int OPW       = fss_pkg::OP_W;
  localparam int NUM_ITEMS = 1850;
  localparam int IDLE_PCT  = 38;
  localparam int HOLD_CYC  = 200;
  localparam int STALL_MAX = 3000;

  typedef struct {
    logic [OPW-1:0]    op;
    logic [CW-1:0]     ch;
    bit                typed;
    fss_pkg::res_t     want;
  } stim_row_t;

  logic clk;
  logic rst;

  fss_stream_if #(.T(fss_pkg::cmd_t)) cmd_if ();
  fss_stream_if #(.T(fss_pkg::res_t)) result_if ();

  fuzzy_subsequence_scorer i_dut (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd_if),
    .result (result_if)
  );

  // scorer state mirror
  logic [CW-1:0]               query_mem [QDEPTH];
  bit   [6:0]                  q_len;
  bit   [6:0]                  m_idx;
  bit   [fss_pkg::SCORE_W-1:0] run_score;
  bit   [fss_pkg::RUN_W-1:0]   run_len;
  bit                          first_ok;
  bit   [7:0]                  first_pos;
  bit   [7:0]                  hay_len;
  bit   [CW-1:0]               prev_ch;

  fss_pkg::res_t expected_scores [$];
  int   mismatches;
  int   items_sent;
  bit   steady;
  bit   hold_request;

  stim_row_t directed_rows [26] = '{
    '{fss_pkg::OP_END,    8'h00, 1'b1, '{14'd0,  1'b0}},
    '{fss_pkg::OP_HAY,    "x",   1'b0, '0},
    '{fss_pkg::OP_END,    8'hff, 1'b1, '{14'd0,  1'b0}},
    '{fss_pkg::OP_APPEND, "A",   1'b0, '0},
    '{fss_pkg::OP_APPEND, "b",   1'b0, '0},
    '{fss_pkg::OP_HAY,    "a",   1'b0, '0},
    '{fss_pkg::OP_HAY,    "B",   1'b0, '0},
    '{fss_pkg::OP_END,    8'h00, 1'b1, '{14'd66, 1'b1}},
    '{fss_pkg::OP_HAY,    "x",   1'b0, '0},
    '{fss_pkg::OP_HAY,    "/",   1'b0, '0},
    '{fss_pkg::OP_HAY,    "A",   1'b0, '0},
    '{fss_pkg::OP_HAY,    " ",   1'b0, '0},
    '{fss_pkg::OP_HAY,    "b",   1'b0, '0},
    '{fss_pkg::OP_HAY,    "z",   1'b0, '0},
    '{fss_pkg::OP_END,    8'h00, 1'b0, '0},
    '{fss_pkg::OP_HAY,    ".",   1'b0, '0},
    '{fss_pkg::OP_APPEND, ".",   1'b0, '0},
    '{fss_pkg::OP_HAY,    "A",   1'b0, '0},
    '{fss_pkg::OP_HAY,    "b",   1'b0, '0},
    '{fss_pkg::OP_END,    8'h00, 1'b1, '{14'd0,  1'b0}},
    '{fss_pkg::OP_CLEAR,  8'hff, 1'b0, '0},
    '{fss_pkg::OP_APPEND, 8'h00, 1'b0, '0},
    '{fss_pkg::OP_APPEND, 8'hff, 1'b0, '0},
    '{fss_pkg::OP_HAY,    8'h00, 1'b0, '0},
    '{fss_pkg::OP_HAY,    8'hff, 1'b0, '0},
    '{fss_pkg::OP_END,    8'h00, 1'b1, '{14'd66, 1'b1}}
  };

  function automatic logic [CW-1:0] lower_case(input logic [CW-1:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic bit [fss_pkg::SCORE_W-1:0] clip_score(input int v);
    return (v > int'(fss_pkg::SCORE_MAX)) ? fss_pkg::SCORE_MAX : v[fss_pkg::SCORE_W-1:0];
  endfunction

  function automatic bit is_letter(input logic [CW-1:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic logic [CW-1:0] pick_char();
    int r;
    logic [CW-1:0] odd_chars [4];
    odd_chars = '{8'h40, 8'h5b, 8'h60, 8'h7b};
    r = $urandom_range(99);
    if (r < 25) return CW'($urandom_range("a", "z"));
    if (r < 50) return CW'($urandom_range("A", "Z"));
    if (r < 58) return fss_pkg::CH_SPACE;
    if (r < 63) return fss_pkg::CH_SLASH;
    if (r < 68) return fss_pkg::CH_DOT;
    if (r < 76) return odd_chars[2'($urandom_range(3))];
    return CW'($urandom_range(255));
  endfunction

  function automatic void restart_scan();
    m_idx     = 0;
    run_score = 0;
    run_len   = 0;
    first_ok  = 0;
    first_pos = 0;
    hay_len   = 0;
    prev_ch   = 0;
  endfunction

  task automatic score_item(input logic [OPW-1:0] op, input logic [CW-1:0] ch,
                            output bit has_res, output fss_pkg::res_t res);
    int add;
    int total;
    bit ok;
    has_res = 0;
    res     = '0;
    case (op)
      fss_pkg::OP_CLEAR: begin
        q_len = 0;
        restart_scan();
      end
      fss_pkg::OP_APPEND: begin
        if (q_len < QDEPTH) begin
          query_mem[q_len[QAW-1:0]] = ch;
          q_len++;
        end
        restart_scan();
      end
      fss_pkg::OP_HAY: begin
        if (m_idx < q_len) begin
          if (lower_case(ch) == lower_case(query_mem[m_idx[QAW-1:0]])) begin
            add = 10 + 5 * int'(run_len);
            if (!first_ok) begin
              first_ok  = 1;
              first_pos = hay_len;
            end
            if (hay_len == 0)
              add += 15;
            else if (prev_ch == fss_pkg::CH_SPACE || prev_ch == fss_pkg::CH_SLASH ||
                     prev_ch == fss_pkg::CH_DOT)
              add += 10;
            run_score = clip_score(int'(run_score) + add);
            if (run_len != fss_pkg::RUN_MAX) run_len++;
            m_idx++;
          end else begin
            run_len = 0;
          end
        end
        if (hay_len != HAY_MAX) hay_len++;
        prev_ch = ch;
      end
      default: begin
        ok    = q_len != 0 && m_idx >= q_len;
        total = 0;
        if (ok) begin
          total = clip_score(int'(run_score) + 50 / (int'(hay_len) + 1));
          if (first_ok) total = clip_score(total + 10 / (int'(first_pos) + 1));
        end
        res.score   = total[fss_pkg::SCORE_W-1:0];
        res.matched = ok;
        has_res     = 1;
        restart_scan();
      end
    endcase
  endtask

  task automatic send_item(input logic [OPW-1:0] op, input logic [CW-1:0] ch,
                           input bit typed, input fss_pkg::res_t want);
    bit            has_res;
    fss_pkg::res_t res;
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_if.valid   <= 1'b1;
    cmd_if.data.op <= op;
    cmd_if.data.ch <= ch;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    items_sent++;
    score_item(op, ch, has_res, res);
    if (has_res) expected_scores.push_back(typed ? want : res);
  endtask

  task automatic wait_drained();
    cmd_if.valid <= 1'b0;
    do @(posedge clk); while (expected_scores.size() != 0);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: random back-pressure plus one long hold-off on request
  initial begin
    result_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 0;
        result_if.ready <= 1'b0;
        repeat (HOLD_CYC) @(posedge clk);
      end else begin
        result_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // scoreboard and stall watchdog
  initial begin
    fss_pkg::res_t want;
    fss_pkg::res_t got;
    int            stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if ((cmd_if.valid && cmd_if.ready) || (result_if.valid && result_if.ready))
        stall = 0;
      else
        stall++;
      if (stall >= STALL_MAX) begin
        $display("tb: failure");
        $finish;
      end
      if (!rst && result_if.valid && result_if.ready) begin
        got = result_if.data;
        if (expected_scores.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: score %0d matched %0d", got.score, got.matched);
        end else begin
          want = expected_scores.pop_front();
          if (got.score !== want.score || got.matched !== want.matched) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: score exp %0d got %0d, matched exp %0d got %0d",
                       want.score, got.score, want.matched, got.matched);
          end
        end
      end
    end
  end

  initial begin
    int          pick;
    int          n;
    int          long_hay_left;
    int          long_query_left;
    bit          hold_done;
    bit          drain_done;
    logic [CW-1:0] c;
    rst             = 1'b1;
    cmd_if.valid    = 1'b0;
    cmd_if.data     = '0;
    mismatches      = 0;
    items_sent      = 0;
    steady          = 0;
    hold_request    = 0;
    hold_done       = 0;
    drain_done      = 0;
    long_hay_left   = 3;
    long_query_left = 3;
    q_len           = 0;
    restart_scan();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_item(directed_rows[i].op, directed_rows[i].ch, directed_rows[i].typed,
                directed_rows[i].want);
    wait_drained();

    while (items_sent < NUM_ITEMS) begin
      if (items_sent >= 400 && !hold_done) begin
        hold_done    = 1;
        hold_request = 1;
      end
      steady = items_sent >= 900 && items_sent < 1200;
      if (items_sent >= 1400 && !drain_done) begin
        drain_done = 1;
        wait_drained();
      end
      pick = $urandom_range(99);
      if (pick < 8) begin
        repeat ($urandom_range(1, 6))
          send_item(OPW'($urandom_range(3)), CW'($urandom_range(255)), 1'b0, '0);
      end else if (pick < 22 || q_len == 0) begin
        send_item(fss_pkg::OP_CLEAR, CW'($urandom_range(255)), 1'b0, '0);
        n = $urandom_range(1, 6);
        if (long_query_left > 0 && $urandom_range(29) == 0) begin
          long_query_left--;
          n = $urandom_range(60, 70);
        end
        repeat (n) send_item(fss_pkg::OP_APPEND, pick_char(), 1'b0, '0);
      end else begin
        if (long_hay_left > 0 && $urandom_range(39) == 0) begin
          long_hay_left--;
          repeat ($urandom_range(250, 290))
            send_item(fss_pkg::OP_HAY, pick_char(), 1'b0, '0);
        end
        for (int k = 0; k < q_len; k++) begin
          while ($urandom_range(99) < 30) send_item(fss_pkg::OP_HAY, pick_char(), 1'b0, '0);
          if ($urandom_range(99) < 6) continue;
          c = query_mem[k[QAW-1:0]];
          if (is_letter(c) && $urandom_range(1)) c ^= 8'h20;
          send_item(fss_pkg::OP_HAY, c, 1'b0, '0);
          if ($urandom_range(99) < 2)
            send_item($urandom_range(1) ? fss_pkg::OP_APPEND : fss_pkg::OP_CLEAR,
                      pick_char(), 1'b0, '0);
        end
        repeat ($urandom_range(0, 3)) send_item(fss_pkg::OP_HAY, pick_char(), 1'b0, '0);
        send_item(fss_pkg::OP_END, CW'($urandom_range(255)), 1'b0, '0);
      end
    end

    steady = 0;
    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
